@@ hw/rtl/mi3_pkg.sv @@
// ---------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse core
// element widths, queue entry type and helpers used by front and back ends
// ---------------------------------------------------------------------------
package mi3_pkg;
	localparam int ElemW  = 32;
	localparam int CofW   = 66;   // exact Q32.32 cofactor (difference of two 64-bit products)
	localparam int DetW   = 100;  // exact Q48.48 determinant
	localparam int NumW   = CofW + 32;
	localparam int QuotW  = NumW;
	localparam int InW    = 9 * ElemW;
	localparam int OutW   = 9 * ElemW;
	localparam int QDepthDefault = 4;

	typedef struct packed {
		logic [8:0][CofW-1:0] adj;
		logic [DetW-1:0]      det;
	} mi3_job_t;
endpackage

@@ hw/rtl/mi3_front.sv @@
// ---------------------------------------------------------------------------
// mi3_front: cofactor and determinant stages
// five registered stages: products, cofactors, split determinant products,
// determinant terms and sum
// ---------------------------------------------------------------------------
module mi3_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [mi3_pkg::InW-1:0] in_data,
	output logic                   job_valid,
	input  logic                   job_ready,
	output mi3_pkg::mi3_job_t      job
);
	import mi3_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv;
	logic signed [ElemW-1:0] e [9];
	logic signed [63:0] pa_s1 [9], pb_s1 [9];
	logic signed [ElemW-1:0] r0_s1 [3], r0_s2 [3];
	logic signed [CofW-1:0] cof_s2 [9], cof_s3 [9], cof_s4 [9], cof_s5 [9];
	logic signed [65:0] tlo_s3 [3];
	logic signed [64:0] thi_s3 [3];
	logic signed [DetW-1:0] t_s4 [3];
	logic signed [DetW-1:0] det_s5;

	function automatic logic signed [63:0] prod(logic signed [ElemW-1:0] a,
			logic signed [ElemW-1:0] b);
		return 64'(a) * 64'(b);
	endfunction

	assign adv = !v_s5 || job_ready;
	assign in_ready = adv;

	always_comb begin
		for (int k = 0; k < 9; k++) e[k] = in_data[k*ElemW +: ElemW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// cofactor product pairs, adjugate order
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1[0] <= prod(e[4], e[8]);  pb_s1[0] <= prod(e[7], e[5]);
			pa_s1[1] <= prod(e[7], e[2]);  pb_s1[1] <= prod(e[1], e[8]);
			pa_s1[2] <= prod(e[1], e[5]);  pb_s1[2] <= prod(e[4], e[2]);
			pa_s1[3] <= prod(e[6], e[5]);  pb_s1[3] <= prod(e[3], e[8]);
			pa_s1[4] <= prod(e[0], e[8]);  pb_s1[4] <= prod(e[6], e[2]);
			pa_s1[5] <= prod(e[3], e[2]);  pb_s1[5] <= prod(e[0], e[5]);
			pa_s1[6] <= prod(e[3], e[7]);  pb_s1[6] <= prod(e[6], e[4]);
			pa_s1[7] <= prod(e[6], e[1]);  pb_s1[7] <= prod(e[0], e[7]);
			pa_s1[8] <= prod(e[0], e[4]);  pb_s1[8] <= prod(e[3], e[1]);
			for (int k = 0; k < 3; k++) r0_s1[k] <= e[k];
			for (int k = 0; k < 9; k++)
				cof_s2[k] <= CofW'(pa_s1[k]) - CofW'(pb_s1[k]);
			for (int k = 0; k < 3; k++) r0_s2[k] <= r0_s1[k];
			// row 0 element times cofactor 0, 3 or 6, split into 33-bit halves
			for (int k = 0; k < 3; k++) begin
				tlo_s3[k] <= 66'(r0_s2[k]) * 66'($signed({1'b0, cof_s2[3*k][32:0]}));
				thi_s3[k] <= 65'(r0_s2[k]) * 65'($signed(cof_s2[3*k][CofW-1:33]));
			end
			for (int k = 0; k < 9; k++) cof_s3[k] <= cof_s2[k];
			for (int k = 0; k < 3; k++)
				t_s4[k] <= (DetW'(thi_s3[k]) <<< 33) + DetW'(tlo_s3[k]);
			for (int k = 0; k < 9; k++) cof_s4[k] <= cof_s3[k];
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			for (int k = 0; k < 9; k++) cof_s5[k] <= cof_s4[k];
		end
	end

	assign job_valid = v_s5;
	always_comb begin
		for (int k = 0; k < 9; k++) job.adj[k] = cof_s5[k];
		job.det = det_s5;
	end
endmodule

@@ hw/rtl/mi3_queue.sv @@
// ---------------------------------------------------------------------------
// mi3_queue: short fifo between front and back ends
// register-based queue, depth set by parameter
// ---------------------------------------------------------------------------
module mi3_queue #(
	parameter int Depth = mi3_pkg::QDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  mi3_pkg::mi3_job_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output mi3_pkg::mi3_job_t rd_data
);
	import mi3_pkg::*;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	mi3_job_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (AW+1)'(Depth) |-> !wr) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !rd) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth)) else $error("queue count out of range");
`endif
endmodule

@@ hw/rtl/mi3_back.sv @@
// ---------------------------------------------------------------------------
// mi3_back: pipelined restoring divider with rounding and saturation
// nine lanes, one quotient bit per stage, elastic valid pipeline
// ---------------------------------------------------------------------------
module mi3_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	output logic                    job_ready,
	input  mi3_pkg::mi3_job_t       job,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [mi3_pkg::OutW-1:0] out_inv,
	output logic                    out_singular
);
	import mi3_pkg::*;
	localparam int NS = QuotW;          // one stage per quotient bit
	localparam int RW = DetW + 1;

	logic adv;
	logic [NS:0] v;
	logic [DetW-1:0] d [NS+1];
	logic sing [NS+1];
	logic [8:0] neg [NS+1];
	logic [NumW-1:0] n [NS+1][9];
	logic [RW-1:0] r [NS+1][9];
	logic [DetW-1:0] dabs;
	logic [8:0] neg_in;
	logic [NumW-1:0] n_in [9];

	assign adv = !v[NS] || out_ready;
	assign job_ready = adv;

	always_comb begin
		dabs = job.det[DetW-1] ? DetW'(-job.det) : job.det;
		for (int k = 0; k < 9; k++) begin
			neg_in[k] = job.adj[k][CofW-1] ^ job.det[DetW-1];
			n_in[k] = {(job.adj[k][CofW-1] ? CofW'(-job.adj[k]) : job.adj[k]), 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (adv) v <= {v[NS-1:0], job_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d[0] <= dabs;
			sing[0] <= job.det == '0;
			neg[0] <= neg_in;
			for (int k = 0; k < 9; k++) begin
				n[0][k] <= n_in[k];
				r[0][k] <= '0;
			end
		end
	end

	// stage s produces quotient bit NS-1-s, shifted into the low end of n
	for (genvar s = 0; s < NS; s++) begin : g_div
		logic [RW-1:0] rs [9];
		logic [RW:0] diff [9];
		always_comb begin
			for (int k = 0; k < 9; k++) begin
				rs[k] = {r[s][k][RW-2:0], n[s][k][NumW-1]};
				diff[k] = {1'b0, rs[k]} - {2'b0, d[s]};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d[s+1] <= d[s];
				sing[s+1] <= sing[s];
				neg[s+1] <= neg[s];
				for (int k = 0; k < 9; k++) begin
					r[s+1][k] <= diff[k][RW] ? rs[k] : diff[k][RW-1:0];
					n[s+1][k] <= {n[s][k][NumW-2:0], !diff[k][RW]};
				end
			end
		end
	end

	// rounding and saturation, combinational after the last divider stage
	logic [NumW:0] qr [9];
	logic [ElemW-1:0] res [9];
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			qr[k] = {1'b0, n[NS][k]} +
				(NumW+1)'({r[NS][k], 1'b0} >= {1'b0, d[NS]});
			if (sing[NS]) res[k] = '0;
			else if (!neg[NS][k])
				res[k] = (qr[k] > (NumW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: qr[k][ElemW-1:0];
			else
				res[k] = (qr[k] > (NumW+1)'(32'h8000_0000)) ? 32'h8000_0000
					: ElemW'(-qr[k][ElemW-1:0]);
			out_inv[k*ElemW +: ElemW] = res[k];
		end
	end
	assign out_singular = sing[NS];
	assign out_valid = v[NS];

`ifndef SYNTHESIS
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_singular |-> out_inv == '0) else $error("singular not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> job_ready) else $error("back end stalled while empty");
`endif
endmodule

@@ hw/rtl/matrix_inverse_3x3_core.sv @@
// ---------------------------------------------------------------------------
// matrix_inverse_3x3_core: 3x3 Q16.16 matrix inverse by the adjugate
// front end forms cofactors and determinant, back end divides and rounds
// ---------------------------------------------------------------------------
// Accepts one matrix every cycle while not stalled by a full queue and returns one
// result per matrix in order. A matrix passes through five front stages, the queue
// (4 entries by default), the divider input register and the 98-stage restoring
// divider, one quotient bit per stage for all nine elements. An output stall holds
// the back end while the queue fills.
// A zero determinant gives zeros and singular.
module matrix_inverse_3x3_core #(
	parameter int QDepth = mi3_pkg::QDepthDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [mi3_pkg::InW-1:0]  s_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [mi3_pkg::OutW-1:0] m_tdata,   // inv_00 .. inv_22
	output logic                     m_tuser    // singular
);
	import mi3_pkg::*;

	mi3_job_t fj, bj;
	logic fv, fr, bv, br;

	mi3_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(s_tdata), .job_valid(fv), .job_ready(fr), .job(fj));
	mi3_queue #(.Depth(QDepth)) u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr),
		.wr_data(fj), .rd_valid(bv), .rd_ready(br), .rd_data(bj));
	mi3_back u_back (.clk, .arst_n, .job_valid(bv), .job_ready(br), .job(bj),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_inv(m_tdata),
		.out_singular(m_tuser));
endmodule

@@ verif/matrix_inverse_3x3_checker.sv @@
// ---------------------------------------------------------------------------
// matrix_inverse_3x3_checker: predicts and checks the 3x3 inverse stream
// watches both channels, computes each inverse exactly and compares in order
// ---------------------------------------------------------------------------
module matrix_inverse_3x3_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [mi3_pkg::InW-1:0]  s_tdata,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [mi3_pkg::OutW-1:0] m_tdata,
	input  logic                     m_tuser,
	output int                       fail_count,
	output int                       pending,
	output int                       checked,
	output int                       singular_seen,
	output int                       saturated_seen
);
	import mi3_pkg::*;

	typedef struct {
		logic [OutW-1:0] inv;
		logic            singular;
	} inverse_t;

	inverse_t expected_inverses[$];

	function automatic logic signed [127:0] elem(logic [InW-1:0] m, int idx);
		return 128'($signed(m[idx*ElemW +: ElemW]));
	endfunction

	// exact quotient round(adj * 2^32 / det), ties away from zero, saturated
	function automatic logic [31:0] divide_round(logic signed [127:0] adj,
			logic signed [127:0] det);
		logic          neg;
		logic [127:0]  num;
		logic [127:0]  den;
		logic [127:0]  q;
		logic [127:0]  r;
		neg = (adj < 0) != (det < 0);
		num = (adj < 0 ? -adj : adj) << 32;
		den = det < 0 ? -det : det;
		q = num / den;
		r = num % den;
		if ((r << 1) >= den)
			q = q + 1;
		if (!neg)
			return q > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
		return q > 128'h8000_0000 ? 32'h8000_0000 : 32'(-q[31:0]);
	endfunction

	function automatic inverse_t invert_matrix(logic [InW-1:0] m);
		logic signed [127:0] a [9];
		logic signed [127:0] adj [9];
		logic signed [127:0] det;
		inverse_t res;
		for (int k = 0; k < 9; k++)
			a[k] = elem(m, k);
		adj[0] = a[4]*a[8] - a[7]*a[5];
		adj[3] = a[6]*a[5] - a[3]*a[8];
		adj[6] = a[3]*a[7] - a[6]*a[4];
		adj[1] = a[7]*a[2] - a[1]*a[8];
		adj[2] = a[1]*a[5] - a[4]*a[2];
		adj[4] = a[0]*a[8] - a[6]*a[2];
		adj[5] = a[3]*a[2] - a[0]*a[5];
		adj[7] = a[6]*a[1] - a[0]*a[7];
		adj[8] = a[0]*a[4] - a[3]*a[1];
		det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
		res.inv = '0;
		res.singular = (det == 0);
		if (!res.singular)
			for (int k = 0; k < 9; k++)
				res.inv[k*ElemW +: ElemW] = divide_round(adj[k], det);
		return res;
	endfunction

	assign pending = expected_inverses.size();

	always @(posedge clk or negedge arst_n) begin
		inverse_t exp_inv;
		logic [31:0] got;
		logic [31:0] want;
		int nfail;
		int nsat;
		if (!arst_n) begin
			fail_count     <= 0;
			checked        <= 0;
			singular_seen  <= 0;
			saturated_seen <= 0;
		end else begin
			nfail = 0;
			nsat = 0;
			if (s_tvalid && s_tready)
				expected_inverses.push_back(invert_matrix(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_inverses.size() == 0) begin
					$display("%0t unexpected result transaction: tdata=%h tuser=%b",
						$time, m_tdata, m_tuser);
					nfail++;
				end else begin
					exp_inv = expected_inverses.pop_front();
					checked <= checked + 1;
					if (exp_inv.singular)
						singular_seen <= singular_seen + 1;
					for (int k = 0; k < 9; k++) begin
						want = exp_inv.inv[k*ElemW +: ElemW];
						got  = m_tdata[k*ElemW +: ElemW];
						if (want == 32'h7FFF_FFFF || want == 32'h8000_0000)
							nsat++;
						if (got !== want) begin
							$display("%0t inv_%0d%0d mismatch: expected %h actual %h",
								$time, k / 3, k % 3, want, got);
							nfail++;
						end
					end
					if (m_tuser !== exp_inv.singular) begin
						$display("%0t singular mismatch: expected %b actual %b",
							$time, exp_inv.singular, m_tuser);
						nfail++;
					end
				end
			end
			fail_count     <= fail_count + nfail;
			saturated_seen <= saturated_seen + nsat;
		end
	end
endmodule

@@ verif/tb_matrix_inverse_3x3_core.sv @@
// ---------------------------------------------------------------------------
// tb_matrix_inverse_3x3_core: stimulus and verdict for the 3x3 inverse core
// directed corner matrices, then random well-formed, singular and raw ones
// ---------------------------------------------------------------------------
module tb_matrix_inverse_3x3_core;
	import mi3_pkg::*;

	localparam int StallLimit = 20000;
	localparam logic [31:0] One    = 32'h0001_0000;
	localparam logic [31:0] NegOne = 32'hFFFF_0000;
	localparam logic [31:0] MaxQ   = 32'h7FFF_FFFF;
	localparam logic [31:0] MinQ   = 32'h8000_0000;

	logic            clk = 0;
	logic            arst_n = 0;
	logic            s_tvalid = 0;
	logic            s_tready;
	logic [InW-1:0]  s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 0;
	logic [OutW-1:0] m_tdata;
	logic            m_tuser;

	int fail_count, pending, checked, singular_seen, saturated_seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	matrix_inverse_3x3_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	matrix_inverse_3x3_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending), .checked(checked),
		.singular_seen(singular_seen), .saturated_seen(saturated_seen)
	);

	always @(posedge clk)
		if (arst_n)
			m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("watchdog: no transaction for %0d cycles", StallLimit);
			$display("status: fail");
			$finish;
		end
	end

	// called in the step just after a rising edge; leaves s_tvalid high
	task automatic send_matrix(logic [31:0] e [9]);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		for (int k = 0; k < 9; k++)
			s_tdata[k*ElemW +: ElemW] <= e[k];
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	function automatic logic [31:0] rand_elem(int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
			default: begin
				case ($urandom_range(6))
					0: return 0;
					1: return One;
					2: return NegOne;
					3: return MaxQ;
					4: return MinQ;
					5: return 1;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic send_random_matrix();
		logic [31:0] e [9];
		int mode;
		int kind;
		mode = $urandom_range(99);
		kind = mode < 45 ? 1 : (mode < 65 ? 0 : 2);
		for (int k = 0; k < 9; k++)
			e[k] = rand_elem(mode < 85 ? kind : $urandom_range(2));
		if (mode >= 65 && mode < 80) begin
			// singular: last row copies or negates another, or a column is zero
			case ($urandom_range(2))
				0: for (int c = 0; c < 3; c++) e[6+c] = e[c];
				1: for (int c = 0; c < 3; c++) e[6+c] = -e[3+c];
				default: for (int r = 0; r < 3; r++) e[r*3+1] = 0;
			endcase
		end else if (mode >= 90) begin
			// diagonal with a wide magnitude spread
			for (int k = 0; k < 9; k++)
				if (k % 4 != 0)
					e[k] = 0;
				else
					e[k] = $urandom >> $urandom_range(31);
		end
		send_matrix(e);
	endtask

	task automatic send_diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
		logic [31:0] e [9];
		for (int k = 0; k < 9; k++)
			e[k] = 0;
		e[0] = d0;
		e[4] = d1;
		e[8] = d2;
		send_matrix(e);
	endtask

	task automatic send_fill(logic [31:0] v);
		logic [31:0] e [9];
		for (int k = 0; k < 9; k++)
			e[k] = v;
		send_matrix(e);
	endtask

	task automatic run_directed();
		logic [31:0] e [9];
		send_diag(One, One, One);
		send_diag(NegOne, One, NegOne);
		send_diag(32'h0002_0000, 32'h0004_0000, 32'h0000_8000);
		send_diag(1, 1, 1);                       // tiny det saturates high
		send_diag(1, NegOne, 1);                  // two elements saturate high, inv_11 is -1.0
		send_diag(MaxQ, MaxQ, MaxQ);              // inverse elements round to 2 LSB
		send_diag(MinQ, MinQ, MinQ);
		send_diag(MinQ, MaxQ, 32'h0003_0000);
		send_diag(32'h0003_0000, 32'h0003_0000, 32'h0003_0000); // rounding of 1/3
		send_fill(0);
		send_fill(MaxQ);
		send_fill(MinQ);
		send_fill(32'hFFFF_FFFF);
		send_fill(One);
		for (int k = 0; k < 9; k++)
			e[k] = (k % 2) ? MinQ : MaxQ;
		send_matrix(e);
		for (int k = 0; k < 9; k++)
			e[k] = 32'(k + 1) << 16;               // 1..9 is singular
		send_matrix(e);
		e[8] = 32'h000A_0000;
		send_matrix(e);
		for (int k = 0; k < 9; k++)
			e[k] = (k == 1 || k == 3 || k == 8) ? One : 0; // permutation
		send_matrix(e);
		for (int k = 0; k < 9; k++)
			e[k] = (k == 2 || k == 4 || k == 6) ? NegOne : 0;
		send_matrix(e);
		for (int k = 0; k < 9; k++)
			e[k] = (k < 3 || k % 4 == 0) ? One : 0;  // upper triangular
		send_matrix(e);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				3: begin idle_pct = 36; stall_pct = 36; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			repeat (phase == 4 ? 200 : 300)
				send_random_matrix();
		end
		s_tvalid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		$display("sent %0d matrices under five idle/stall mixes; checked %0d inverses",
			sent, checked);
		$display("singular results %0d, saturated elements %0d", singular_seen,
			saturated_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
